FILE: hw/rtl/bpc_pkg.sv
// Package for the barometric pressure compensation block.
// Holds calibration-field widths, constants and the calibration record type.
`default_nettype none
package bpc_pkg;
   localparam int unsigned NUM_CAL = 5;
   localparam int unsigned CAL_W   = 32;
   localparam int unsigned IDX_W   = 3;

   localparam logic [IDX_W-1:0] IDX_AC1_AC2 = 3'd0;
   localparam logic [IDX_W-1:0] IDX_AC3_AC4 = 3'd1;
   localparam logic [IDX_W-1:0] IDX_AC5_AC6 = 3'd2;
   localparam logic [IDX_W-1:0] IDX_B1_B2   = 3'd3;
   localparam logic [IDX_W-1:0] IDX_MC_MD   = 3'd4;

   localparam logic [31:0] K_B6_OFS  = 32'd4000;
   localparam logic [31:0] K_P_MUL1  = 32'd3038;
   localparam logic [31:0] K_P_MUL2  = 32'hFFFF_E343; // -7357
   localparam logic [31:0] K_P_OFS   = 32'd3791;
   localparam logic [31:0] K_B4_OFS  = 32'd32768;
   localparam logic [31:0] K_B7_MUL  = 32'd50000;

   typedef struct packed {
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   } cal_type;

   function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
      asr32 = 32'($signed(v) >>> n);
   endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/bpc_udiv.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Uses bpc_pkg; carries a side tag of TAG_W bits with each item.
`default_nettype none
module bpc_udiv #(
   parameter int unsigned TAG_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [31:0]      in_num,
   input  wire logic [31:0]      in_den,
   input  wire logic [TAG_W-1:0] in_tag,
   output logic                  out_valid,
   output logic [31:0]           out_quo,
   output logic [TAG_W-1:0]      out_tag
);
   import bpc_pkg::*;

   logic [31:0]      rem_ff [1:32];
   logic [31:0]      quo_ff [1:32];
   logic [31:0]      den_ff [1:32];
   logic [TAG_W-1:0] tag_ff [1:32];
   logic             vld_ff [1:32];

   for (genvar s = 0; s < 32; s++) begin : g_stage
      logic [31:0]      rem_cur, quo_cur, den_cur;
      logic [TAG_W-1:0] tag_cur;
      logic             vld_cur;
      logic [32:0]      sh_in;
      logic [32:0]      diff_in;
      if (s == 0) begin : g_head
         always_comb begin
            rem_cur = '0;
            quo_cur = in_num;
            den_cur = in_den;
            tag_cur = in_tag;
            vld_cur = in_valid;
         end
      end else begin : g_body
         always_comb begin
            rem_cur = rem_ff[s];
            quo_cur = quo_ff[s];
            den_cur = den_ff[s];
            tag_cur = tag_ff[s];
            vld_cur = vld_ff[s];
         end
      end
      always_comb begin
         sh_in   = {rem_cur, quo_cur[31]};
         diff_in = sh_in - {1'b0, den_cur};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_cur;
         end
         if (!diff_in[32]) begin
            rem_ff[s+1] <= diff_in[31:0];
            quo_ff[s+1] <= {quo_cur[30:0], 1'b1};
         end else begin
            rem_ff[s+1] <= sh_in[31:0];
            quo_ff[s+1] <= {quo_cur[30:0], 1'b0};
         end
         den_ff[s+1] <= den_cur;
         tag_ff[s+1] <= tag_cur;
      end
   end

   assign out_valid = vld_ff[32];
   assign out_quo   = quo_ff[32];
   assign out_tag   = tag_ff[32];
endmodule
`default_nettype wire

FILE: hw/rtl/bpc_temp_path.sv
// Temperature front end: X1, divisor check, signed division, B5 and temperature.
// Uses bpc_pkg and bpc_udiv.
`default_nettype none
module bpc_temp_path (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [15:0]      in_ut,
   input  wire logic [15:0]      in_up,
   input  wire bpc_pkg::cal_type cal,
   output logic                  out_valid,
   output logic [31:0]           out_b5,
   output logic [31:0]           out_temp,
   output logic [15:0]           out_up,
   output logic                  out_err
);
   import bpc_pkg::*;

   localparam int unsigned TW = 32 + 16 + 1 + 2;

   // stage 1: multiply
   logic        v1_ff;
   logic [31:0] m1_ff;
   logic [15:0] up1_ff;
   // stage 2: x1 and divisor
   logic        v2_ff;
   logic [31:0] x1_2_ff, den2_ff, num2_ff;
   logic [15:0] up2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      m1_ff   <= ({16'd0, in_ut} - cal.ac6) * cal.ac5;
      up1_ff  <= in_up;
      x1_2_ff <= asr32(m1_ff, 15);
      den2_ff <= asr32(m1_ff, 15) + cal.md;
      num2_ff <= cal.mc << 11;
      up2_ff  <= up1_ff;
   end

   // magnitudes for the unsigned divider
   logic [31:0] an_in, ad_in;
   logic        neg_in, zero_in;
   always_comb begin
      an_in   = num2_ff[31] ? 32'(-num2_ff) : num2_ff;
      ad_in   = den2_ff[31] ? 32'(-den2_ff) : den2_ff;
      neg_in  = num2_ff[31] ^ den2_ff[31];
      zero_in = (den2_ff == '0);
   end

   logic          dv;
   logic [31:0]   dq;
   logic [TW-1:0] dtag;
   bpc_udiv #(.TAG_W(TW)) u_div (
      .clock, .reset,
      .in_valid (v2_ff),
      .in_num   (an_in),
      .in_den   (ad_in),
      .in_tag   ({x1_2_ff, up2_ff, neg_in, zero_in, 1'b0}),
      .out_valid(dv),
      .out_quo  (dq),
      .out_tag  (dtag)
   );

   logic [31:0] x1_d, x2_d, b5_d;
   always_comb begin
      x1_d = dtag[TW-1 -: 32];
      x2_d = dtag[2] ? 32'(-dq) : dq;
      b5_d = x1_d + x2_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= dv;
      end
      out_b5   <= b5_d;
      out_temp <= asr32(b5_d + 32'd8, 4);
      out_up   <= dtag[18:3];
      out_err  <= dtag[1];
   end
endmodule
`default_nettype wire

FILE: hw/rtl/bpc_press_path.sv
// Pressure back end: B6..B4, B7, unsigned division and final correction.
// Uses bpc_pkg and bpc_udiv.
`default_nettype none
module bpc_press_path (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [31:0]      in_b5,
   input  wire logic [31:0]      in_temp,
   input  wire logic [15:0]      in_up,
   input  wire logic             in_err,
   input  wire bpc_pkg::cal_type cal,
   output logic                  out_valid,
   output logic [31:0]           out_temp,
   output logic [31:0]           out_p,
   output logic                  out_err
);
   import bpc_pkg::*;

   localparam int unsigned TW = 32 + 1 + 1;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [31:0] b6_1_ff, t1_ff, sqm_ff;
   logic [15:0] up1_ff, up2_ff, up3_ff, up4_ff;
   logic        e1_ff, e2_ff, e3_ff, e4_ff;
   logic [31:0] t2_ff, t3_ff, t4_ff;
   logic [31:0] m_b2_ff, m_ac2_ff, m_ac3_ff, m_b1_ff;
   logic [31:0] b3_3_ff, x3_3_ff;
   logic [31:0] b4m_ff, b7m_ff;

   logic [31:0] sq_c, b3n_c, b3_c, x3p_c;
   always_comb begin
      sq_c  = asr32(sqm_ff, 12);
      b3n_c = cal.ac1 * 32'd4 + asr32(m_b2_ff, 11) + asr32(m_ac2_ff, 11) + 32'd2;
      b3_c  = 32'($signed(b3n_c) / 4);
      x3p_c = asr32(asr32(m_ac3_ff, 13) + asr32(m_b1_ff, 16) + 32'd2, 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
      // stage 1: B6 and its square
      b6_1_ff <= in_b5 - K_B6_OFS;
      sqm_ff  <= (in_b5 - K_B6_OFS) * (in_b5 - K_B6_OFS);
      t1_ff <= in_temp; up1_ff <= in_up; e1_ff <= in_err;
      // stage 2: products with calibration words
      m_b2_ff  <= cal.b2 * sq_c;
      m_ac2_ff <= cal.ac2 * b6_1_ff;
      m_ac3_ff <= cal.ac3 * b6_1_ff;
      m_b1_ff  <= cal.b1 * sq_c;
      t2_ff <= t1_ff; up2_ff <= up1_ff; e2_ff <= e1_ff;
      // stage 3: B3 and X3
      b3_3_ff <= b3_c;
      x3_3_ff <= x3p_c;
      t3_ff <= t2_ff; up3_ff <= up2_ff; e3_ff <= e2_ff;
      // stage 4: B4 and B7 products
      b4m_ff <= cal.ac4 * (x3_3_ff + K_B4_OFS);
      b7m_ff <= ({16'd0, up3_ff} - b3_3_ff) * K_B7_MUL;
      t4_ff <= t3_ff; up4_ff <= up3_ff; e4_ff <= e3_ff;
   end

   logic [31:0] b4_c, num_c;
   logic        big_c, err_c;
   always_comb begin
      b4_c  = b4m_ff >> 15;
      big_c = b7m_ff[31];
      num_c = big_c ? b7m_ff : {b7m_ff[30:0], 1'b0};
      err_c = e4_ff | (b4_c == '0);
   end

   logic          dv;
   logic [31:0]   dq;
   logic [TW-1:0] dtag;
   bpc_udiv #(.TAG_W(TW)) u_div (
      .clock, .reset,
      .in_valid (v4_ff),
      .in_num   (num_c),
      .in_den   (b4_c),
      .in_tag   ({t4_ff, big_c, err_c}),
      .out_valid(dv),
      .out_quo  (dq),
      .out_tag  (dtag)
   );

   // final correction, three stages
   logic        w1_ff, w2_ff;
   logic [31:0] p1_ff, p2_ff, pt1_ff, pt2_ff, sqp_ff, x1m_ff, x2m1_ff, x2m_ff;
   logic        pe1_ff, pe2_ff;
   logic [31:0] p_c;
   always_comb p_c = dtag[1] ? {dq[30:0], 1'b0} : dq;

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_ff <= 1'b0; w2_ff <= 1'b0; out_valid <= 1'b0;
      end else begin
         w1_ff <= dv; w2_ff <= w1_ff; out_valid <= w2_ff;
      end
      p1_ff   <= p_c;
      sqp_ff  <= asr32(p_c, 8) * asr32(p_c, 8);
      x2m1_ff <= p_c * K_P_MUL2;
      pt1_ff <= dtag[TW-1 -: 32]; pe1_ff <= dtag[0];
      p2_ff  <= p1_ff;
      x1m_ff <= sqp_ff * K_P_MUL1;
      x2m_ff <= x2m1_ff;
      pt2_ff <= pt1_ff; pe2_ff <= pe1_ff;
      out_p    <= p2_ff + asr32(asr32(x1m_ff, 16) + asr32(x2m_ff, 16) + K_P_OFS, 4);
      out_temp <= pt2_ff;
      out_err  <= pe2_ff;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/barometric_pressure_compensation_top.sv
// Throughput: one request per cycle; the two 32-stage dividers set the depth.
// busy stays low, the receiver cannot stall, so every request is taken at once.
// Reset is synchronous: it clears the calibration registers and all valid bits.
// Uses bpc_pkg, bpc_temp_path, bpc_press_path.
`default_nettype none
module barometric_pressure_compensation_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [15:0]               req_raw_temperature,
   input  wire logic [15:0]               req_raw_pressure,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_temperature_tenths,
   output logic signed [31:0]             rsp_pressure_pa,
   output logic                           rsp_status,
   input  wire logic                      csr_we,
   input  wire logic [bpc_pkg::IDX_W-1:0] csr_index,
   input  wire logic [bpc_pkg::CAL_W-1:0] csr_wdata
);
   import bpc_pkg::*;

   logic [CAL_W-1:0] cal_ff [0:NUM_CAL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CAL; i++) cal_ff[i] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            IDX_AC1_AC2: cal_ff[0] <= csr_wdata;
            IDX_AC3_AC4: cal_ff[1] <= csr_wdata;
            IDX_AC5_AC6: cal_ff[2] <= csr_wdata;
            IDX_B1_B2:   cal_ff[3] <= csr_wdata;
            IDX_MC_MD:   cal_ff[4] <= csr_wdata;
            default: ;
         endcase
      end
   end

   cal_type cal;
   always_comb begin
      cal.ac1 = {{16{cal_ff[0][31]}}, cal_ff[0][31:16]};
      cal.ac2 = {{16{cal_ff[0][15]}}, cal_ff[0][15:0]};
      cal.ac3 = {{16{cal_ff[1][31]}}, cal_ff[1][31:16]};
      cal.ac4 = {16'd0, cal_ff[1][15:0]};
      cal.ac5 = {16'd0, cal_ff[2][31:16]};
      cal.ac6 = {16'd0, cal_ff[2][15:0]};
      cal.b1  = {{16{cal_ff[3][31]}}, cal_ff[3][31:16]};
      cal.b2  = {{16{cal_ff[3][15]}}, cal_ff[3][15:0]};
      cal.mc  = {{16{cal_ff[4][31]}}, cal_ff[4][31:16]};
      cal.md  = {{16{cal_ff[4][15]}}, cal_ff[4][15:0]};
   end

   assign busy = 1'b0;

   logic        tv, terr;
   logic [31:0] tb5, ttemp;
   logic [15:0] tup;
   bpc_temp_path u_temp (
      .clock, .reset,
      .in_valid (start & ~busy),
      .in_ut    (req_raw_temperature),
      .in_up    (req_raw_pressure),
      .cal,
      .out_valid(tv), .out_b5(tb5), .out_temp(ttemp), .out_up(tup), .out_err(terr)
   );

   logic        pv, perr;
   logic [31:0] ptemp, pp;
   bpc_press_path u_press (
      .clock, .reset,
      .in_valid(tv), .in_b5(tb5), .in_temp(ttemp), .in_up(tup), .in_err(terr),
      .cal,
      .out_valid(pv), .out_temp(ptemp), .out_p(pp), .out_err(perr)
   );

   always_comb begin
      rsp_valid              = pv;
      rsp_status             = perr;
      rsp_temperature_tenths = perr ? '0 : $signed(ptemp);
      rsp_pressure_pa        = perr ? '0 : $signed(pp);
   end

   a_busy_low: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy asserted");
   // first edge after reset drops; valid bits were cleared by then
   a_rsp_after_reset: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("response right after reset");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_pressure_pa == 0 && rsp_temperature_tenths == 0)
      else $error("error response not zeroed");
endmodule
`default_nettype wire
